@@ rtl/prw_pkg.sv @@
// Shared constants, types and helpers for the Prewitt horizontal gradient core.
package prw_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned PixelW     = 8;
  localparam int unsigned GradW      = 11;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned SumW       = PixelW + 2;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgIndexW  = 2;

  typedef logic [ColW-1:0]   col_t;
  typedef logic [RowW-1:0]   row_t;
  typedef logic [PixelW-1:0] pixel_t;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_index_e;

  // One line store entry: the pixel one row up and the one two rows up.
  typedef struct packed {
    pixel_t prev2;
    pixel_t prev1;
  } line_t;

  // Last column index for a written width, clamped to 3..MaxWidth.
  function automatic col_t width_last(input logic [CfgWidthW-1:0] v);
    logic [CfgWidthW-1:0] m;
    if (v < CfgWidthW'(3)) begin
      m = CfgWidthW'(2);
    end else if (v > CfgWidthW'(MaxWidth)) begin
      m = CfgWidthW'(MaxWidth - 1);
    end else begin
      m = v - CfgWidthW'(1);
    end
    return m[ColW-1:0];
  endfunction

  // Last row index for a written height, clamped to 3..MaxHeight.
  function automatic row_t height_last(input logic [CfgHeightW-1:0] v);
    logic [CfgHeightW-1:0] m;
    if (v < CfgHeightW'(3)) begin
      m = CfgHeightW'(2);
    end else if (v > CfgHeightW'(MaxHeight)) begin
      m = CfgHeightW'(MaxHeight - 1);
    end else begin
      m = v - CfgHeightW'(1);
    end
    return m[RowW-1:0];
  endfunction

endpackage

@@ rtl/prw_line_mem.sv @@
// Two line stores packed into one synchronous RAM, one write and one read port.
module prw_line_mem (
  input  logic           clk_i,
  input  logic           we_i,
  input  prw_pkg::col_t  waddr_i,
  input  prw_pkg::line_t wdata_i,
  input  logic           re_i,
  input  prw_pkg::col_t  raddr_i,
  output prw_pkg::line_t rdata_o
);
  import prw_pkg::*;

  line_t mem [MaxWidth];
  line_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/prw_window.sv @@
// 3x3 window kept as column sums; forms left column minus right column.
module prw_window (
  input  logic                              clk_i,
  input  logic                              shift_i,
  input  prw_pkg::pixel_t                   px_i,
  input  prw_pkg::line_t                    line_i,
  output logic signed [prw_pkg::GradW-1:0]  gradient_o
);
  import prw_pkg::*;

  logic [SumW-1:0] col_sum;
  logic [SumW-1:0] sum1_q, sum1_d;
  logic [SumW-1:0] sum2_q, sum2_d;

  assign col_sum = SumW'(line_i.prev2) + SumW'(line_i.prev1) + SumW'(px_i);

  // after the shift the left column is what was the middle one
  assign gradient_o = $signed({1'b0, sum1_q}) - $signed({1'b0, col_sum});

  always_comb begin
    sum1_d = sum1_q;
    sum2_d = sum2_q;
    if (shift_i) begin
      sum1_d = sum2_q;
      sum2_d = col_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    sum1_q <= sum1_d;
    sum2_q <= sum2_d;
  end

endmodule

@@ rtl/prewitt_3x3_horizontal_gradient_core.sv @@
// Top level of the Prewitt 3x3 horizontal gradient core.
// Usage:
//   Pixels enter in raster order on pixel_i with pixel_valid_i; a request is
//   taken at a rising edge with pixel_valid_i high and pixel_stall_o low.
//   Results leave on gradient_o / frame_end_o with result_valid_o and are
//   taken when result_stall_i is low. Only interior pixels give a result;
//   frame_end_o marks the last interior result of a frame.
//   Throughput is one pixel per clock unless a held result stalls it,
//   set by the single read-modify-write of the line store RAM per pixel
//   (read at accept, write when stage 1 fires). An accepted pixel passes
//   stage 1 (RAM read) and the output register before result_valid_o.
//   image_width / image_height are written through cfg_we_i, cfg_index_i,
//   cfg_data_i while idle; a write restarts the frame at row 0, column 0.
//   Reset clears the counters, the pipeline valids and sets 640 x 480; the
//   line stores are not cleared and need no clearing pass.
//   When result_stall_i holds a result, the core keeps taking pixels until
//   the next result would need the output register, then raises
//   pixel_stall_o.
module prewitt_3x3_horizontal_gradient_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [prw_pkg::CfgIndexW-1:0]          cfg_index_i,
  input  logic [prw_pkg::CfgDataW-1:0]           cfg_data_i,
  input  logic                                   pixel_valid_i,
  output logic                                   pixel_stall_o,
  input  logic [prw_pkg::PixelW-1:0]             pixel_i,
  output logic                                   result_valid_o,
  input  logic                                   result_stall_i,
  output logic signed [prw_pkg::GradW-1:0]       gradient_o,
  output logic                                   frame_end_o
);
  import prw_pkg::*;

  col_t   w_last_q, w_last_d;
  row_t   h_last_q, h_last_d;
  col_t   col_q, col_d;
  row_t   row_q, row_d;

  logic   s1_valid_q, s1_valid_d;
  pixel_t s1_px_q;
  col_t   s1_addr_q;
  logic   s1_prod_q;
  logic   s1_last_q;

  logic   out_valid_q, out_valid_d;
  logic signed [GradW-1:0] out_grad_q;
  logic   out_last_q;

  logic   out_busy, s1_adv, s1_fire, accept;
  line_t  rd_line, wr_line;
  logic signed [GradW-1:0] grad;

  assign out_busy = out_valid_q && result_stall_i;
  assign s1_adv   = !s1_valid_q || !s1_prod_q || !out_busy;
  assign s1_fire  = s1_valid_q && s1_adv;
  assign accept   = pixel_valid_i && s1_adv;
  assign pixel_stall_o = !s1_adv;

  // configuration and position counters
  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    col_d    = col_q;
    row_d    = row_q;
    if (accept) begin
      if (col_q >= w_last_q) begin
        col_d = '0;
        row_d = (row_q >= h_last_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          w_last_d = width_last(cfg_data_i[CfgWidthW-1:0]);
          col_d    = '0;
          row_d    = '0;
        end
        CFG_IMAGE_HEIGHT: begin
          h_last_d = height_last(cfg_data_i[CfgHeightW-1:0]);
          col_d    = '0;
          row_d    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= ColW'(639);
      h_last_q <= RowW'(479);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // stage 1: waits for line store read data
  assign s1_valid_d = s1_adv ? accept : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_addr_q <= col_q;
      s1_prod_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
      s1_last_q <= (row_q == h_last_q) && (col_q == w_last_q);
    end
  end

  assign wr_line.prev2 = rd_line.prev1;
  assign wr_line.prev1 = s1_px_q;

  prw_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_line),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_line)
  );

  prw_window u_window (
    .clk_i      (clk_i),
    .shift_i    (s1_fire),
    .px_i       (s1_px_q),
    .line_i     (rd_line),
    .gradient_o (grad)
  );

  // output register
  assign out_valid_d = out_busy ? 1'b1 : (s1_fire && s1_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_prod_q) begin
      out_grad_q <= grad;
      out_last_q <= s1_last_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign gradient_o     = out_grad_q;
  assign frame_end_o    = out_last_q;

`ifndef SYNTHESIS
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel did not reach stage 1");

  a_frame_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && col_q == w_last_q && row_q == h_last_q)
      |=> (col_q == '0 && row_q == '0))
    else $error("counters did not wrap at frame end");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_prod_q))
    else $error("result appeared without an interior pixel");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_prod_q && out_busy) |=> $stable(out_grad_q))
    else $error("held result overwritten");
`endif

endmodule
